// ===== rtl/dsched_pkg.sv =====
// Shared types and constants for the disk request scheduler.
// No dependencies; every other file in rtl/ but dsched_ram imports this package.
package dsched_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LAST_BLOCK      = 255;

    // Wide enough for a wrap charge: LAST_BLOCK + (LAST_BLOCK - head) + block
    localparam int AMT_W = $clog2(2 * LAST_BLOCK + 256);

    localparam logic [1:0] POL_FCFS  = 2'd0;
    localparam logic [1:0] POL_SSTF  = 2'd1;
    localparam logic [1:0] POL_CSCAN = 2'd2;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PICKED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef enum logic {
        CMD_ENQ  = 1'b0,
        CMD_PICK = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic       op;
        logic [7:0] block;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  chosen_block;
        logic [7:0]  head_pos;
        logic [31:0] travelled;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] block;
    } t_cmd;

endpackage

// ===== rtl/dsched_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsched_front.sv =====
// Front end: accepts input items, decodes them into commands and holds
// them in a two-entry queue for the back end. Depends on dsched_pkg.
module dsched_front
    import dsched_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.block = i_in_data.block;
        case (i_in_data.op)
            1'b1:    cmd_in.kind = CMD_PICK;
            default: cmd_in.kind = CMD_ENQ;
        endcase
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/dsched_back.sv =====
// Back end: pending-request store, policy register, pick scan, travel
// accounting, queue compaction and the output register.
// Depends on dsched_pkg and dsched_ram.
module dsched_back
    import dsched_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [AMT_W-1:0] LAST_AMT = AMT_W'(LAST_BLOCK);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_ADD,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [1:0]       r_policy;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_head;
    logic [31:0]      r_travel;
    logic [CNT_W-1:0] r_ptr;
    logic             r_dv;
    logic [IDX_W-1:0] r_dv_idx;
    logic             r_found;
    logic [7:0]       r_best_d;
    logic [IDX_W-1:0] r_best_idx;
    logic [7:0]       r_best_blk;
    logic [IDX_W-1:0] r_min_idx;
    logic [7:0]       r_min_blk;
    logic [IDX_W-1:0] r_sel_idx;
    logic [7:0]       r_chosen;
    logic [AMT_W-1:0] r_amount;
    logic [1:0]       r_status;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       rd_data;
    logic             issue;
    logic             cand;
    logic [7:0]       seek_d;
    logic [7:0]       cand_d;
    logic             take_best;
    logic             take_min;
    logic             wrap;
    logic [7:0]       calc_chosen;
    logic [AMT_W-1:0] back_amt;
    logic [AMT_W-1:0] calc_amount;
    logic [32:0]      travel_sum;
    logic             out_load;

    dsched_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign issue     = (r_ptr < r_count);

    // store write: append on enqueue, move one entry down during compaction
    always_comb begin
        if (r_state == S_IDLE) begin
            ram_we    = i_cmd_valid && (i_cmd.kind == CMD_ENQ) && (r_count != FULL_CNT);
            ram_waddr = r_count[IDX_W-1:0];
            ram_wdata = i_cmd.block;
        end else begin
            ram_we    = (r_state == S_SHIFT) && r_dv;
            ram_waddr = r_dv_idx - IDX_W'(1);
            ram_wdata = rd_data;
        end
    end

    // per-entry scan compare; first come first served sees every distance as 0
    always_comb begin
        seek_d = (rd_data >= r_head) ? (rd_data - r_head) : (r_head - rd_data);
        case (r_policy)
            POL_SSTF: begin
                cand   = 1'b1;
                cand_d = seek_d;
            end
            POL_CSCAN: begin
                cand   = (rd_data >= r_head);
                cand_d = rd_data - r_head;
            end
            default: begin
                cand   = 1'b1;
                cand_d = 8'd0;
            end
        endcase
        take_best = r_dv && cand && (!r_found || (cand_d < r_best_d));
        take_min  = r_dv && ((r_dv_idx == '0) || (rd_data < r_min_blk));
    end

    // wrap: nothing at or above the head, sweep to the end and back to 0
    always_comb begin
        wrap        = (r_policy == POL_CSCAN) && !r_found;
        calc_chosen = wrap ? r_min_blk : r_best_blk;
        back_amt    = (AMT_W'(r_head) <= LAST_AMT) ? (LAST_AMT - AMT_W'(r_head)) : '0;
        if (wrap) begin
            calc_amount = LAST_AMT + back_amt + AMT_W'(calc_chosen);
        end else if (calc_chosen >= r_head) begin
            calc_amount = AMT_W'(calc_chosen - r_head);
        end else begin
            calc_amount = AMT_W'(r_head - calc_chosen);
        end
        travel_sum = {1'b0, r_travel} + 33'(r_amount);
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_FCFS;
            r_count     <= '0;
            r_head      <= 8'd0;
            r_travel    <= 32'd0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_chosen <= 8'd0;
                        r_ptr    <= '0;
                        r_dv     <= 1'b0;
                        r_found  <= 1'b0;
                        if (i_cmd.kind == CMD_ENQ) begin
                            if (r_count == FULL_CNT) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_status <= ST_ENQUEUED;
                                r_count  <= r_count + CNT_W'(1);
                            end
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_dv <= issue;
                    if (issue) begin
                        r_ptr    <= r_ptr + CNT_W'(1);
                        r_dv_idx <= r_ptr[IDX_W-1:0];
                    end
                    if (take_best) begin
                        r_found    <= 1'b1;
                        r_best_d   <= cand_d;
                        r_best_idx <= r_dv_idx;
                        r_best_blk <= rd_data;
                    end
                    if (take_min) begin
                        r_min_idx <= r_dv_idx;
                        r_min_blk <= rd_data;
                    end
                    if (r_ptr == r_count) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_chosen  <= calc_chosen;
                    r_sel_idx <= wrap ? r_min_idx : r_best_idx;
                    r_amount  <= calc_amount;
                    r_state   <= S_ADD;
                end
                S_ADD: begin
                    r_travel <= travel_sum[32] ? 32'hFFFF_FFFF : travel_sum[31:0];
                    r_head   <= r_chosen;
                    r_ptr    <= CNT_W'(r_sel_idx) + CNT_W'(1);
                    r_dv     <= 1'b0;
                    r_state  <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_dv <= issue;
                    if (issue) begin
                        r_ptr    <= r_ptr + CNT_W'(1);
                        r_dv_idx <= r_ptr[IDX_W-1:0];
                    end
                    if ((r_ptr == r_count) && !r_dv) begin
                        r_count  <= r_count - CNT_W'(1);
                        r_status <= ST_PICKED;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.status       <= r_status;
                        r_out.chosen_block <= r_chosen;
                        r_out.head_pos     <= r_head;
                        r_out.travelled    <= r_travel;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/disk_request_scheduler_top.sv =====
// Disk request scheduler, top level: front end, command queue, back end.
// Depends on dsched_pkg, dsched_front, dsched_back.
//
// Items are handled one at a time by the back end; the front end keeps up
// to two further items queued and the result register lets the next item
// start while a result is still stalled. An enqueue, a rejected enqueue or
// an empty pick goes from the idle state to the done state and then into
// the result register. A pick passes through the scan, calc, add, shift
// and done states; the pending store has one read port, so the selection
// scan reads one entry per cycle and removing the picked entry moves each
// later entry down one per cycle.
// The policy register may only be written while no item is in flight.
module disk_request_scheduler_top
    import dsched_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    dsched_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    dsched_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== rtl/dsched_chk.sv =====
// Port-level checks on the scheduler's result channel, bound to the top.
// Depends on dsched_pkg and disk_request_scheduler_top.
module dsched_chk
    import dsched_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    logic        r_seen;
    logic [31:0] r_last_travel;
    logic        out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_xfer) begin
            r_seen        <= 1'b1;
            r_last_travel <= o_out_data.travelled;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_no_pick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_PICKED) |-> o_out_data.chosen_block == 8'd0)
        else $error("chosen block nonzero without a pick");

    a_head_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_PICKED)
            |-> o_out_data.head_pos == o_out_data.chosen_block)
        else $error("head not at picked block");

    a_travel_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen |-> o_out_data.travelled >= r_last_travel)
        else $error("travel total decreased");

endmodule

bind disk_request_scheduler_top dsched_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
